### rtl/tws_pkg.sv
// Shared constants and phase codes for the TIG weld sequencer.
`default_nettype none
package tws_pkg;
   localparam int ADC_BITS_DEF  = 12;
   localparam int TICK_BITS_DEF = 16;

   localparam int MA_W = 18;           // signed multiplicand
   localparam int MB_W = 16;           // unsigned multiplier
   localparam int MP_W = MA_W + MB_W;  // signed product
   localparam int DN_W = 32;           // dividend width
   localparam int DD_W = 16;           // divisor width

   localparam logic [15:0] CUR_SCALE = 16'd17037;
   localparam logic [16:0] CUR_MAX   = 17'd131071;
   localparam logic signed [18:0] INTEG_LIM = 19'sd128000;
   localparam logic [11:0] DUTY_MAX  = 12'd4000;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_PREGAS    = 3'd1;
   localparam logic [2:0] PH_IGNITION  = 3'd2;
   localparam logic [2:0] PH_WELDING   = 3'd3;
   localparam logic [2:0] PH_DOWNSLOPE = 3'd4;
   localparam logic [2:0] PH_POSTGAS   = 3'd5;

   localparam logic [2:0] REG_MAIN_CURRENT = 3'd0;
   localparam logic [2:0] REG_PRE_GAS      = 3'd1;
   localparam logic [2:0] REG_POST_GAS     = 3'd2;
   localparam logic [2:0] REG_DOWN_SLOPE   = 3'd3;
   localparam logic [2:0] REG_IGN_TIMEOUT  = 3'd4;
   localparam logic [2:0] REG_ARC_THRESH   = 3'd5;
   localparam logic [2:0] REG_KP_GAIN      = 3'd6;
   localparam logic [2:0] REG_KI_GAIN      = 3'd7;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_CUR  = 7'b0000010,
      S_KI   = 7'b0000100,
      S_KP   = 7'b0001000,
      S_SEQ  = 7'b0010000,
      S_DMUL = 7'b0100000,
      S_DIV  = 7'b1000000
   } seq_state_type;
endpackage
`default_nettype wire

### rtl/tws_sermul.sv
// Bit-serial shift-add multiplier, signed by unsigned, one multiplier bit per cycle.
`default_nettype none
module tws_sermul import tws_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic signed [MA_W-1:0] a_in,
   input  wire logic [MB_W-1:0]        b_in,
   output logic                        done,
   output logic signed [MP_W-1:0]      prod
);
   localparam int CNT_W = $clog2(MB_W + 1);

   logic signed [MP_W-1:0] acc_ff, a_ff;
   logic [MB_W-1:0]        b_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   busy_ff, done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            acc_ff  <= '0;
            a_ff    <= MP_W'(a_in);
            b_ff    <= b_in;
            cnt_ff  <= CNT_W'(MB_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (b_ff[0]) acc_ff <= acc_ff + a_ff;
            a_ff   <= a_ff <<< 1;
            b_ff   <= b_ff >> 1;
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule
`default_nettype wire

### rtl/tws_serdiv.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tws_serdiv import tws_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [DN_W-1:0] dividend,
   input  wire logic [DD_W-1:0] divisor,
   output logic                 done,
   output logic [DN_W-1:0]      quotient
);
   localparam int CNT_W = $clog2(DN_W + 1);

   logic [DN_W-1:0]  q_ff;
   logic [DD_W-1:0]  rem_ff, d_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DD_W:0]    rem_sh;

   assign rem_sh = {rem_ff, q_ff[DN_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            q_ff    <= dividend;
            d_ff    <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= CNT_W'(DN_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (rem_sh >= {1'b0, d_ff}) begin
               rem_ff <= DD_W'(rem_sh - {1'b0, d_ff});
               q_ff   <= {q_ff[DN_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[DD_W-1:0];
               q_ff   <= {q_ff[DN_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule
`default_nettype wire

### rtl/tig_weld_sequencer_pi.sv
// TIG weld sequencer with per-tick PI current regulator, top level.
//
//  channel | ports                        | direction | carries
//  req     | req_valid/req_ready + fields | in        | one 1 ms tick: torch, ADC sample
//  rsp     | rsp_valid/rsp_ready + fields | out       | phase, drives, duty, currents
//  csr     | csr_wr_en, csr_index, wdata  | in        | register writes, no wait
//
// Each multiply runs on the shared serial multiplier (start, load, 16 bit steps),
// each divide on the restoring divider. In idle, pre-gas and post-gas the result
// waits only on the current product; in the arc phases on the current, ki and kp
// products; on a down-slope ramp step also on the ramp product and the divide.
// Only one request is in flight at a time; the next is taken the cycle after the
// result leaves.
// Reset is synchronous; it restores register defaults and clears the control registers.
// A waiting result sits in the output register; the block holds there until it
// is taken, then accepts the next request.
`default_nettype none
module tig_weld_sequencer_pi import tws_pkg::*; #(
   parameter int ADC_BITS  = ADC_BITS_DEF,
   parameter int TICK_BITS = TICK_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_torch_pressed,
   input  wire logic [ADC_BITS-1:0] req_adc_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [2:0]               rsp_phase_code,
   output logic                     rsp_gas_valve,
   output logic                     rsp_hf_relay,
   output logic                     rsp_display_blank,
   output logic [11:0]              rsp_duty,
   output logic [16:0]              rsp_measured_current,
   output logic [15:0]              rsp_target_current,
   input  wire logic                csr_wr_en,
   input  wire logic [2:0]          csr_index,
   input  wire logic [15:0]         csr_wdata
);
   localparam int CW = (TICK_BITS > 16) ? TICK_BITS : 16;
   localparam logic [ADC_BITS:0] ADC_FULL = {1'b0, {ADC_BITS{1'b1}}};

   // configuration registers
   logic [7:0]  main_current_ff, arc_thresh_ff;
   logic [15:0] pre_gas_ff, post_gas_ff, down_slope_ff, ign_timeout_ff;
   logic [15:0] kp_ff, ki_ff;

   // sequencer state
   seq_state_type          state_ff;
   logic [2:0]             phase_ff;
   logic [TICK_BITS-1:0]   elapsed_ff;
   logic [15:0]            setpoint_ff;
   logic signed [17:0]     integral_ff;
   logic                   gas_ff, relay_ff, blank_ff;

   // per-request working registers
   logic                   torch_ff;
   logic [16:0]            cur_ff;
   logic signed [17:0]     err_ff;
   logic [11:0]            duty_ff;

   // output register
   logic                   rsp_valid_ff;
   logic [2:0]             o_phase_ff;
   logic                   o_gas_ff, o_relay_ff, o_blank_ff;
   logic [11:0]            o_duty_ff;
   logic [16:0]            o_cur_ff;
   logic [15:0]            o_sp_ff;

   // shared arithmetic
   logic                   mul_start_ff, div_start_ff;
   logic signed [MA_W-1:0] mul_a_ff;
   logic [MB_W-1:0]        mul_b_ff;
   logic                   mul_done, div_done;
   logic signed [MP_W-1:0] mul_prod;
   logic [DN_W-1:0]        div_quot;

   tws_sermul u_mul (
      .clock (clock), .reset (reset), .start (mul_start_ff),
      .a_in (mul_a_ff), .b_in (mul_b_ff), .done (mul_done), .prod (mul_prod)
   );

   tws_serdiv u_div (
      .clock (clock), .reset (reset), .start (div_start_ff),
      .dividend (DN_W'(mul_prod[DN_W-1:0])), .divisor (down_slope_ff),
      .done (div_done), .quotient (div_quot)
   );

   // rectified sample: |2*raw - full|
   logic [ADC_BITS:0] raw2, diff_in;
   assign raw2    = {req_adc_sample, 1'b0};
   assign diff_in = (raw2 >= ADC_FULL) ? raw2 - ADC_FULL : ADC_FULL - raw2;

   // current scaling, >>10 with saturation
   logic [MP_W-11:0] cur_wide;
   logic [16:0]      cur_in;
   assign cur_wide = mul_prod[MP_W-1:10];
   assign cur_in   = (cur_wide > (MP_W-10)'(CUR_MAX)) ? CUR_MAX : cur_wide[16:0];

   // integral update with saturation at +-500 duty counts in Q8
   logic signed [18:0] integ_sum, integ_in;
   assign integ_sum = {integral_ff[17], integral_ff} +
                      19'($signed(mul_prod[MP_W-1:16]));
   always_comb begin
      priority if (integ_sum > INTEG_LIM)  integ_in = INTEG_LIM;
      else if (integ_sum < -INTEG_LIM)     integ_in = -INTEG_LIM;
      else                                 integ_in = integ_sum;
   end

   // regulator output and duty clamp
   logic signed [18:0] pi_out;
   logic [11:0]        duty_in;
   assign pi_out = 19'($signed(mul_prod[MP_W-1:16])) + {integral_ff[17], integral_ff};
   always_comb begin
      priority if (pi_out <= 19'sd0)               duty_in = '0;
      else if ({1'b0, pi_out[18:8]} > DUTY_MAX)    duty_in = DUTY_MAX;
      else                                         duty_in = {1'b0, pi_out[18:8]};
   end

   // elapsed count, saturating
   logic [TICK_BITS-1:0] elapsed_in;
   logic [CW-1:0]        e_cw;
   logic [15:0]          full_sp;
   assign elapsed_in = (&elapsed_ff) ? elapsed_ff : elapsed_ff + 1'b1;
   assign e_cw       = CW'(elapsed_in);
   assign full_sp    = {main_current_ff, 8'h00};

   logic arc_phase;
   assign arc_phase = (phase_ff == PH_IGNITION) || (phase_ff == PH_WELDING) ||
                      (phase_ff == PH_DOWNSLOPE);

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_current_ff <= 8'd80;
         pre_gas_ff      <= 16'd500;
         post_gas_ff     <= 16'd3000;
         down_slope_ff   <= 16'd2000;
         ign_timeout_ff  <= 16'd2000;
         arc_thresh_ff   <= 8'd10;
         kp_ff           <= 16'd9830;
         ki_ff           <= 16'd3277;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_MAIN_CURRENT: main_current_ff <= csr_wdata[7:0];
            REG_PRE_GAS:      pre_gas_ff      <= csr_wdata;
            REG_POST_GAS:     post_gas_ff     <= csr_wdata;
            REG_DOWN_SLOPE:   down_slope_ff   <= csr_wdata;
            REG_IGN_TIMEOUT:  ign_timeout_ff  <= csr_wdata;
            REG_ARC_THRESH:   arc_thresh_ff   <= csr_wdata[7:0];
            REG_KP_GAIN:      kp_ff           <= csr_wdata;
            REG_KI_GAIN:      ki_ff           <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_IDLE;
         elapsed_ff   <= '0;
         setpoint_ff  <= '0;
         integral_ff  <= '0;
         gas_ff       <= 1'b0;
         relay_ff     <= 1'b0;
         blank_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  torch_ff     <= req_torch_pressed;
                  mul_a_ff     <= MA_W'(diff_in);
                  mul_b_ff     <= CUR_SCALE;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_CUR;
               end
            end
            S_CUR: begin
               if (mul_done) begin
                  cur_ff <= cur_in;
                  if (arc_phase) begin
                     err_ff       <= $signed({2'b00, setpoint_ff}) - $signed({1'b0, cur_in});
                     mul_a_ff     <= $signed({2'b00, setpoint_ff}) - $signed({1'b0, cur_in});
                     mul_b_ff     <= ki_ff;
                     mul_start_ff <= 1'b1;
                     state_ff     <= S_KI;
                  end else begin
                     integral_ff <= '0;
                     duty_ff     <= '0;
                     state_ff    <= S_SEQ;
                  end
               end
            end
            S_KI: begin
               if (mul_done) begin
                  integral_ff  <= integ_in[17:0];
                  mul_a_ff     <= err_ff;
                  mul_b_ff     <= kp_ff;
                  mul_start_ff <= 1'b1;
                  state_ff     <= S_KP;
               end
            end
            S_KP: begin
               if (mul_done) begin
                  duty_ff  <= duty_in;
                  state_ff <= S_SEQ;
               end
            end
            S_SEQ: begin
               // sequencer step runs once the result slot is free
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= S_IDLE;
                  unique case (phase_ff)
                     PH_IDLE: begin
                        elapsed_ff <= '0;
                        if (torch_ff) begin
                           blank_ff <= 1'b1;
                           gas_ff   <= 1'b1;
                           phase_ff <= PH_PREGAS;
                        end
                     end
                     PH_PREGAS: begin
                        if (e_cw > CW'(pre_gas_ff)) begin
                           relay_ff   <= 1'b1;
                           phase_ff   <= PH_IGNITION;
                           elapsed_ff <= '0;
                        end else begin
                           elapsed_ff <= elapsed_in;
                        end
                     end
                     PH_IGNITION: begin
                        if (cur_ff > {1'b0, arc_thresh_ff, 8'h00} ||
                            e_cw > CW'(ign_timeout_ff)) begin
                           relay_ff   <= 1'b0;
                           phase_ff   <= torch_ff ? PH_WELDING : PH_DOWNSLOPE;
                           elapsed_ff <= '0;
                        end else begin
                           elapsed_ff <= elapsed_in;
                        end
                     end
                     PH_WELDING: begin
                        setpoint_ff <= full_sp;
                        if (!torch_ff) begin
                           phase_ff   <= PH_DOWNSLOPE;
                           elapsed_ff <= '0;
                        end else begin
                           elapsed_ff <= elapsed_in;
                        end
                     end
                     PH_DOWNSLOPE: begin
                        if (e_cw > CW'(down_slope_ff)) begin
                           setpoint_ff <= '0;
                           phase_ff    <= PH_POSTGAS;
                           elapsed_ff  <= '0;
                        end else begin
                           elapsed_ff <= elapsed_in;
                           if (down_slope_ff == '0) begin
                              setpoint_ff <= full_sp;
                           end else begin
                              // ramp: full*(T-e)/T over multiplier then divider
                              mul_a_ff     <= MA_W'(full_sp);
                              mul_b_ff     <= down_slope_ff - e_cw[15:0];
                              mul_start_ff <= 1'b1;
                              state_ff     <= S_DMUL;
                           end
                        end
                     end
                     PH_POSTGAS: begin
                        if (e_cw > CW'(post_gas_ff)) begin
                           gas_ff     <= 1'b0;
                           blank_ff   <= 1'b0;
                           phase_ff   <= PH_IDLE;
                           elapsed_ff <= '0;
                        end else begin
                           elapsed_ff <= elapsed_in;
                        end
                     end
                     default: begin
                        phase_ff   <= PH_IDLE;
                        elapsed_ff <= '0;
                     end
                  endcase
               end
            end
            S_DMUL: begin
               if (mul_done) begin
                  div_start_ff <= 1'b1;
                  state_ff     <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  setpoint_ff <= div_quot[15:0];
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase

         // the result leaves as the request completes
         if ((state_ff == S_SEQ && (!rsp_valid_ff || rsp_ready) &&
              !(phase_ff == PH_DOWNSLOPE && !(e_cw > CW'(down_slope_ff)) &&
                down_slope_ff != '0)) ||
             (state_ff == S_DIV && div_done)) begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   // output payload: captured from the next-state values as the request completes
   logic [2:0] phase_nx;
   logic       gas_nx, relay_nx, blank_nx;
   logic [15:0] sp_nx;
   always_comb begin
      phase_nx = phase_ff;
      gas_nx   = gas_ff;
      relay_nx = relay_ff;
      blank_nx = blank_ff;
      sp_nx    = setpoint_ff;
      unique case (phase_ff)
         PH_IDLE: if (torch_ff) begin
            phase_nx = PH_PREGAS; gas_nx = 1'b1; blank_nx = 1'b1;
         end
         PH_PREGAS: if (e_cw > CW'(pre_gas_ff)) begin
            phase_nx = PH_IGNITION; relay_nx = 1'b1;
         end
         PH_IGNITION: if (cur_ff > {1'b0, arc_thresh_ff, 8'h00} ||
                          e_cw > CW'(ign_timeout_ff)) begin
            relay_nx = 1'b0; phase_nx = torch_ff ? PH_WELDING : PH_DOWNSLOPE;
         end
         PH_WELDING: begin
            sp_nx = full_sp;
            if (!torch_ff) phase_nx = PH_DOWNSLOPE;
         end
         PH_DOWNSLOPE: begin
            if (e_cw > CW'(down_slope_ff)) begin
               sp_nx = '0; phase_nx = PH_POSTGAS;
            end else if (down_slope_ff == '0) begin
               sp_nx = full_sp;
            end
         end
         PH_POSTGAS: if (e_cw > CW'(post_gas_ff)) begin
            phase_nx = PH_IDLE; gas_nx = 1'b0; blank_nx = 1'b0;
         end
         default: phase_nx = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SEQ && (!rsp_valid_ff || rsp_ready)) begin
         o_phase_ff <= phase_nx;
         o_gas_ff   <= gas_nx;
         o_relay_ff <= relay_nx;
         o_blank_ff <= blank_nx;
         o_duty_ff  <= duty_ff;
         o_cur_ff   <= cur_ff;
         o_sp_ff    <= sp_nx;
      end else if (state_ff == S_DIV && div_done) begin
         o_sp_ff <= div_quot[15:0];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_phase_code       = o_phase_ff;
   assign rsp_gas_valve        = o_gas_ff;
   assign rsp_hf_relay         = o_relay_ff;
   assign rsp_display_blank    = o_blank_ff;
   assign rsp_duty             = o_duty_ff;
   assign rsp_measured_current = o_cur_ff;
   assign rsp_target_current   = o_sp_ff;

   a_integ_bound: assert property (@(posedge clock) disable iff (reset)
      (integral_ff <= 18'sd128000) && (integral_ff >= -18'sd128000))
      else $error("integrator out of bounds");

   a_duty_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (o_duty_ff <= DUTY_MAX))
      else $error("duty above limit");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while busy");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_POSTGAS)
      else $error("phase register out of range");
endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the TIG weld sequencer with PI current regulator.
`default_nettype none
module testbench;
   import tws_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 100;   // margin after the last result is back
   localparam int N_DIR       = 25;
   localparam int N_CFG       = 8;
   localparam int PER_CFG     = 105;

   typedef struct packed {
      logic [2:0]  phase;
      logic        gas;
      logic        relay;
      logic        blank;
      logic [11:0] duty;
      logic [16:0] cur;
      logic [15:0] target;
   } weld_rsp_type;

   // one directed request; 'load' drains and loads setting 0 before it
   typedef struct {
      logic         torch;
      logic [11:0]  adc;
      bit           typed;
      bit           load;
      weld_rsp_type want;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_torch_pressed = 1'b0;
   logic [11:0] req_adc_sample = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_phase_code;
   logic        rsp_gas_valve;
   logic        rsp_hf_relay;
   logic        rsp_display_blank;
   logic [11:0] rsp_duty;
   logic [16:0] rsp_measured_current;
   logic [15:0] rsp_target_current;
   logic        csr_wr_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   tig_weld_sequencer_pi u_top (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // predictor copy of registers and sequencer state
   logic [7:0]  m_main = 8'd80, m_arc = 8'd10;
   logic [15:0] m_pre = 16'd500, m_post = 16'd3000, m_down = 16'd2000;
   logic [15:0] m_ign = 16'd2000, m_kp = 16'd9830, m_ki = 16'd3277;
   logic [2:0]  w_phase = PH_IDLE;
   logic [15:0] w_elapsed = '0, w_setpoint = '0;
   longint      w_integ = 0;
   logic        w_gas = 1'b0, w_relay = 1'b0, w_blank = 1'b0;

   weld_rsp_type tick_results [$];
   int        n_fail = 0;
   int        n_sent = 0;
   int        snd_idle = 15, rcv_idle = 72;
   int        cycles = 0;

   // register settings, in register index order
   logic [15:0] cfg_sets [0:N_CFG-1][0:7] = '{
      '{16'd200, 16'd1, 16'd2, 16'd0, 16'd3, 16'd10, 16'd65535, 16'd65535},
      '{16'd80, 16'd3, 16'd5, 16'd7, 16'd4, 16'd10, 16'd9830, 16'd3277},
      '{16'd10, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0},
      '{16'd255, 16'd2, 16'd4, 16'd10, 16'd65535, 16'd255, 16'd65535, 16'd65535},
      '{16'd120, 16'd5, 16'd3, 16'd65535, 16'd6, 16'd20, 16'd30000, 16'd1000},
      '{16'd150, 16'd1, 16'd1, 16'd3, 16'd2, 16'd5, 16'd20000, 16'd60000},
      '{16'd100, 16'd60000, 16'd2, 16'd2, 16'd2, 16'd10, 16'd5000, 16'd5000},
      '{16'd200, 16'd0, 16'd1, 16'd2, 16'd1, 16'd40, 16'd12000, 16'd2000}
   };

   // first four rows run on reset registers, idle, so the result is obvious:
   // mid-scale reads 16/256 A, either rail reads 68131/256 A
   dir_row_type dir_tab [0:N_DIR-1] = '{
      '{1'b0, 12'd2048, 1'b1, 1'b0, '{PH_IDLE, 1'b0, 1'b0, 1'b0, 12'd0, 17'd16, 16'd0}},
      '{1'b0, 12'd0, 1'b1, 1'b0, '{PH_IDLE, 1'b0, 1'b0, 1'b0, 12'd0, 17'd68131, 16'd0}},
      '{1'b0, 12'd4095, 1'b1, 1'b0, '{PH_IDLE, 1'b0, 1'b0, 1'b0, 12'd0, 17'd68131, 16'd0}},
      '{1'b0, 12'd2047, 1'b1, 1'b0, '{PH_IDLE, 1'b0, 1'b0, 1'b0, 12'd0, 17'd16, 16'd0}},
      // short times: pre-gas, arc strike on a rail sample, weld, release
      '{1'b1, 12'd2048, 1'b0, 1'b1, '0},
      '{1'b1, 12'd2048, 1'b0, 1'b0, '0},
      '{1'b1, 12'd2048, 1'b0, 1'b0, '0},
      '{1'b1, 12'd2048, 1'b0, 1'b0, '0},
      '{1'b1, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b1, 12'd2048, 1'b0, 1'b0, '0},
      '{1'b1, 12'd0, 1'b0, 1'b0, '0},
      '{1'b1, 12'd3000, 1'b0, 1'b0, '0},
      '{1'b1, 12'd4095, 1'b0, 1'b0, '0},
      '{1'b0, 12'd2100, 1'b0, 1'b0, '0},
      // zero ramp time: straight through down-slope into post-gas
      '{1'b0, 12'd2048, 1'b0, 1'b0, '0},
      '{1'b0, 12'd2048, 1'b0, 1'b0, '0},
      '{1'b0, 12'd2048, 1'b0, 1'b0, '0},
      '{1'b0, 12'd2048, 1'b0, 1'b0, '0},
      // new weld; no arc, ignition times out with the torch released
      '{1'b1, 12'd2048, 1'b0, 1'b0, '0},
      '{1'b1, 12'd2048, 1'b0, 1'b0, '0},
      '{1'b0, 12'd2048, 1'b0, 1'b0, '0},
      '{1'b0, 12'd2050, 1'b0, 1'b0, '0},
      '{1'b0, 12'd2045, 1'b0, 1'b0, '0},
      '{1'b0, 12'd2048, 1'b0, 1'b0, '0},
      '{1'b0, 12'd2048, 1'b0, 1'b0, '0}
   };

   // one tick of the regulator and sequencer
   function automatic weld_rsp_type weld_tick(input logic torch, input logic [11:0] adc);
      weld_rsp_type r;
      longint    twice, diff, cur, e, err, o, duty;
      twice = 2 * longint'(adc);
      diff  = (twice >= 4095) ? twice - 4095 : 4095 - twice;
      cur   = (diff * 17037) >>> 10;
      if (cur > 131071) cur = 131071;
      e    = (w_elapsed == 16'hFFFF) ? 65535 : longint'(w_elapsed) + 1;
      duty = 0;

      // PI runs on the phase and setpoint left by the previous tick
      if (w_phase == PH_IGNITION || w_phase == PH_WELDING || w_phase == PH_DOWNSLOPE) begin
         err = longint'(w_setpoint) - cur;
         w_integ = w_integ + ((err * longint'(m_ki)) >>> 16);
         if (w_integ > 128000) w_integ = 128000;
         if (w_integ < -128000) w_integ = -128000;
         o = ((err * longint'(m_kp)) >>> 16) + w_integ;
         if (o > 0) duty = ((o >>> 8) > 4000) ? 4000 : (o >>> 8);
      end else begin
         w_integ = 0;
      end

      case (w_phase)
         PH_IDLE: begin
            w_elapsed = '0;
            if (torch) begin
               w_blank = 1'b1; w_gas = 1'b1; w_phase = PH_PREGAS;
            end
         end
         PH_PREGAS: begin
            if (e > m_pre) begin
               w_relay = 1'b1; w_phase = PH_IGNITION; w_elapsed = '0;
            end else w_elapsed = e[15:0];
         end
         PH_IGNITION: begin
            if (cur > longint'(m_arc) * 256 || e > m_ign) begin
               w_relay = 1'b0;
               w_phase = torch ? PH_WELDING : PH_DOWNSLOPE;
               w_elapsed = '0;
            end else w_elapsed = e[15:0];
         end
         PH_WELDING: begin
            w_setpoint = {m_main, 8'h00};
            if (!torch) begin
               w_phase = PH_DOWNSLOPE; w_elapsed = '0;
            end else w_elapsed = e[15:0];
         end
         PH_DOWNSLOPE: begin
            if (e > m_down) begin
               w_setpoint = '0; w_phase = PH_POSTGAS; w_elapsed = '0;
            end else begin
               // linear ramp; a zero ramp time would hold full current
               if (m_down == 0) w_setpoint = {m_main, 8'h00};
               else w_setpoint = 16'((longint'(m_main) * 256 * (longint'(m_down) - e))
                                     / longint'(m_down));
               w_elapsed = e[15:0];
            end
         end
         PH_POSTGAS: begin
            if (e > m_post) begin
               w_gas = 1'b0; w_blank = 1'b0; w_phase = PH_IDLE; w_elapsed = '0;
            end else w_elapsed = e[15:0];
         end
         default: begin
            w_phase = PH_IDLE; w_elapsed = '0;
         end
      endcase

      r.phase  = w_phase;
      r.gas    = w_gas;
      r.relay  = w_relay;
      r.blank  = w_blank;
      r.duty   = duty[11:0];
      r.cur    = cur[16:0];
      r.target = w_setpoint;
      return r;
   endfunction

   // request channel: valid stays up after acceptance so back-to-back requests
   // never lower and raise it in one step; lower_req drops it explicitly
   task automatic send_tick(input logic torch, input logic [11:0] adc, input bit typed,
                            input weld_rsp_type want);
      weld_rsp_type r;
      if ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_idle);
      end
      req_valid         <= 1'b1;
      req_torch_pressed <= torch;
      req_adc_sample    <= adc;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = weld_tick(torch, adc);
      tick_results.push_back(typed ? want : r);
      n_sent++;
      // idling pattern: sender light / receiver heavy, then swapped, then none
      if (n_sent == 283) begin snd_idle = 72; rcv_idle = 15; end
      if (n_sent == 566) begin snd_idle = 0; rcv_idle = 0; end
   endtask

   task automatic lower_req();
      req_valid <= 1'b0;
   endtask

   // every request yields a result, so an empty queue plus a margin is idle
   task automatic drain();
      lower_req();
      while (tick_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic load_setting(input int k);
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= i[2:0];
         csr_wdata <= cfg_sets[k][i];
         @(posedge clock);
         case (i[2:0])
            REG_MAIN_CURRENT: m_main = cfg_sets[k][i][7:0];
            REG_PRE_GAS:      m_pre  = cfg_sets[k][i];
            REG_POST_GAS:     m_post = cfg_sets[k][i];
            REG_DOWN_SLOPE:   m_down = cfg_sets[k][i];
            REG_IGN_TIMEOUT:  m_ign  = cfg_sets[k][i];
            REG_ARC_THRESH:   m_arc  = cfg_sets[k][i][7:0];
            REG_KP_GAIN:      m_kp   = cfg_sets[k][i];
            REG_KI_GAIN:      m_ki   = cfg_sets[k][i];
            default: ;
         endcase
      end
      csr_wr_en <= 1'b0;
   endtask

   // sample spread: near mid-scale, anywhere, or hard against a rail
   function automatic logic [11:0] pick_adc();
      case ($urandom_range(2))
         0: return 12'($urandom_range(2048 - 60, 2048 + 60));
         1: return 12'($urandom_range(4095));
         default: return $urandom_range(1) ? 12'($urandom_range(15))
                                            : 12'($urandom_range(4080, 4095));
      endcase
   endfunction

   // result channel: random back-pressure and in-order comparison
   always @(posedge clock) begin
      weld_rsp_type w;
      rsp_ready <= ($urandom_range(99) >= rcv_idle);
      if (rsp_valid && rsp_ready) begin
         if (tick_results.size() == 0) begin
            $error("result with no request outstanding");
            n_fail++;
         end else begin
            w = tick_results.pop_front();
            if (rsp_phase_code !== w.phase) begin
               $error("phase_code: expected %0d, got %0d", w.phase, rsp_phase_code);
               n_fail++;
            end
            if (rsp_gas_valve !== w.gas) begin
               $error("gas_valve: expected %0d, got %0d", w.gas, rsp_gas_valve);
               n_fail++;
            end
            if (rsp_hf_relay !== w.relay) begin
               $error("hf_relay: expected %0d, got %0d", w.relay, rsp_hf_relay);
               n_fail++;
            end
            if (rsp_display_blank !== w.blank) begin
               $error("display_blank: expected %0d, got %0d", w.blank, rsp_display_blank);
               n_fail++;
            end
            if (rsp_duty !== w.duty) begin
               $error("duty: expected %0d, got %0d", w.duty, rsp_duty);
               n_fail++;
            end
            if (rsp_measured_current !== w.cur) begin
               $error("measured_current: expected %0d, got %0d", w.cur,
                      rsp_measured_current);
               n_fail++;
            end
            if (rsp_target_current !== w.target) begin
               $error("target_current: expected %0d, got %0d", w.target,
                      rsp_target_current);
               n_fail++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      int        held, left;
      logic      torch;
      bit        paused;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < N_DIR; i++) begin
         if (dir_tab[i].load) begin
            drain();
            load_setting(0);
         end
         send_tick(dir_tab[i].torch, dir_tab[i].adc, dir_tab[i].typed, dir_tab[i].want);
      end

      // random part: mostly whole welds (press, hold, release), some noise
      for (int k = 1; k <= N_CFG; k++) begin
         drain();
         load_setting(k % N_CFG);
         left = PER_CFG;
         while (left > 0) begin
            if ($urandom_range(9) < 8) begin
               held = $urandom_range(1, 25);
               for (int t = 0; t < held + $urandom_range(1, 15) && left > 0; t++) begin
                  send_tick(t < held, pick_adc(), 1'b0, '0);
                  left--;
               end
            end else begin
               torch = 1'($urandom_range(1));
               send_tick(torch, pick_adc(), 1'b0, '0);
               left--;
            end
            // sender holds off mid-run until everything is back
            if (k == 4 && !paused && left <= PER_CFG / 2) begin
               paused = 1'b1;
               lower_req();
               while (tick_results.size() != 0) @(posedge clock);
            end
         end
      end

      drain();
      if (n_fail == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
rtl/tws_pkg.sv
rtl/tws_sermul.sv
rtl/tws_serdiv.sv
rtl/tig_weld_sequencer_pi.sv
tb/sv/testbench.sv
